// ----- sv/ght_pkg.sv -----
// Package for the generational handle table: sizes, request and status codes,
// and the packed result and divider types. No dependencies.
package ght_pkg;
    localparam int SLOTS      = 256;
    localparam int INDEX_BITS = 8;
    localparam int POS_BITS   = $clog2(SLOTS + 1);
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_DESTROY = 2'd1;
    localparam logic [1:0] REQ_HAS     = 2'd2;
    localparam logic [1:0] REQ_EVAL    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

    localparam int IN_BITS  = 144;
    localparam int OUT_BITS = 88;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [31:0] unit_out;
        logic [15:0] frame_sel;
        logic        present;
        logic [31:0] new_handle;
        logic [1:0]  status;
    } t_result;

    // Divider command and answer between the table and the divide unit.
    typedef struct packed {
        logic        start;
        logic [31:0] play_time;
        logic [15:0] frames;
        logic [31:0] duration;
    } t_div_cmd;

    typedef struct packed {
        logic        done;
        logic [15:0] frame_sel;
    } t_div_rsp;
endpackage

// ----- sv/generational_handle_table_core.sv -----
// Top level of the generational handle table: slot and dense memories,
// request sequencer and result register. Depends on ght_pkg and ght_div.
//
// Usage: one request item enters on the s_axis channel; tuser carries
// req_type and tdata packs handle, frame_count, duration, play_time and
// unit_id from bit 0. Each request gives exactly one result item on m_axis;
// tdata packs status, new_handle, present, frame_sel and unit_out from bit 0.
// Create, has and any request on a stale handle pass through the states
// RD1, CHK and OUT; a destroy passes through RD1, CHK, RD2, ACT, FIX and
// OUT. The sequencer reads the slot memory, then the dense memories, one
// registered read port each.
// Evaluate runs RD1, CHK, RD2, ACT, then the bit-serial divider in DIV:
// 16 multiply steps, 48 divide steps and one clamp step, then OUT.
// One request is worked at a time; s_axis_tready is high only while the
// sequencer is idle and no result waits.
// After reset the slot memory is swept once, one slot per cycle,
// while no request is accepted.
// A result waits in the output register while m_axis_tready is low; the next
// request is not accepted until that result has been taken.
module generational_handle_table_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    // handle[31:0], frame_count[47:32], duration[79:48], play_time[111:80],
    // unit_id[143:112]
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], new_handle[33:2], present[34], frame_sel[50:35],
    // unit_out[82:51], zero fill above
    output logic [87:0]  m_axis_tdata
);
    import ght_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_RD2   = 4'd4;
    localparam logic [3:0] S_ACT   = 4'd5;
    localparam logic [3:0] S_FIX   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // Slot memories: handle, dense position, next free slot.
    logic [31:0]         m_shdl [SLOTS];
    logic [POS_BITS-1:0] m_spos [SLOTS];
    logic [SLOT_BITS-1:0] m_snxt [SLOTS];
    // Dense memories.
    logic [31:0] m_dhdl [SLOTS];
    logic [15:0] m_dfrm [SLOTS];
    logic [31:0] m_ddur [SLOTS];

    logic [3:0]           r_st;
    logic [SLOT_BITS:0]   r_clr;
    logic [SLOT_BITS-1:0] r_head, r_tail;
    logic [POS_BITS-1:0]  r_live;
    logic [1:0]           r_req;
    logic [31:0]          r_h, r_dur, r_t, r_unit;
    logic [15:0]          r_frm;
    logic [SLOT_BITS-1:0] r_sa;
    logic [31:0]          r_rshdl;
    logic [POS_BITS-1:0]  r_rspos;
    logic [SLOT_BITS-1:0] r_rsnxt;
    logic [SLOT_BITS-1:0] r_da;
    logic [31:0]          r_rdhdl, r_rddur;
    logic [15:0]          r_rdfrm;
    logic [POS_BITS-1:0]  r_pos;
    logic                 r_ovalid;
    t_result              r_res;
    t_div_cmd             w_cmd;
    t_div_rsp             w_rsp;
    logic                 w_live;
    logic [SLOT_BITS-1:0] w_last;

    // Slot number field of the handle, widened to 32 bits for the check against SLOTS.
    assign w_live = ({{(32-INDEX_BITS){1'b0}}, r_h[INDEX_BITS-1:0]} < 32'(SLOTS))
                    && r_rspos < POS_BITS'(SLOTS) && r_rshdl == r_h;
    assign w_last = SLOT_BITS'(r_live - POS_BITS'(1));

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_res};

    assign w_cmd.start     = (r_st == S_ACT) && (r_req == REQ_EVAL) && w_live;
    assign w_cmd.play_time = r_t;
    assign w_cmd.frames    = r_rdfrm;
    assign w_cmd.duration  = r_rddur;

    ght_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_rsp(w_rsp));

    // Registered reads of slot and dense memories.
    always_ff @(posedge i_clk) begin
        r_rshdl <= m_shdl[r_sa];
        r_rspos <= m_spos[r_sa];
        r_rsnxt <= m_snxt[r_sa];
        r_rdhdl <= m_dhdl[r_da];
        r_rdfrm <= m_dfrm[r_da];
        r_rddur <= m_ddur[r_da];
    end

    // Sequencer with memory writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_clr <= '0; r_head <= '0;
            r_tail <= SLOT_BITS'(SLOTS - 1); r_live <= '0; r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_CLEAR: begin
                    m_shdl[r_clr[SLOT_BITS-1:0]] <= 32'(r_clr);
                    m_spos[r_clr[SLOT_BITS-1:0]] <= POS_BITS'(SLOTS);
                    m_snxt[r_clr[SLOT_BITS-1:0]] <=
                        SLOT_BITS'(r_clr + (SLOT_BITS+1)'(1));
                    r_clr <= r_clr + (SLOT_BITS+1)'(1);
                    if (r_clr == (SLOT_BITS+1)'(SLOTS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_req  <= s_axis_tuser;
                        r_h    <= s_axis_tdata[31:0];
                        r_frm  <= s_axis_tdata[47:32];
                        r_dur  <= s_axis_tdata[79:48];
                        r_t    <= s_axis_tdata[111:80];
                        r_unit <= s_axis_tdata[143:112];
                        r_res  <= '0;
                        if (s_axis_tuser == REQ_CREATE) r_sa <= r_head;
                        else r_sa <= s_axis_tdata[SLOT_BITS-1:0];
                        r_st <= S_RD1;
                    end
                end
                S_RD1: r_st <= S_CHK;
                S_CHK: begin
                    unique case (r_req)
                        REQ_CREATE: begin
                            if (r_live >= POS_BITS'(SLOTS)) begin
                                r_res.status <= ST_FULL; r_st <= S_OUT;
                            end else begin
                                m_shdl[r_sa] <= r_rshdl + 32'(1 << INDEX_BITS);
                                m_spos[r_sa] <= r_live;
                                m_dhdl[r_live[SLOT_BITS-1:0]] <= r_rshdl + 32'(1 << INDEX_BITS);
                                m_dfrm[r_live[SLOT_BITS-1:0]] <= r_frm;
                                m_ddur[r_live[SLOT_BITS-1:0]] <= r_dur;
                                r_head <= r_rsnxt;
                                r_live <= r_live + POS_BITS'(1);
                                r_res.new_handle <= r_rshdl + 32'(1 << INDEX_BITS);
                                r_st <= S_OUT;
                            end
                        end
                        REQ_HAS: begin
                            r_res.present <= w_live; r_st <= S_OUT;
                        end
                        REQ_DESTROY: begin
                            if (!w_live) begin
                                r_res.status <= ST_STALE; r_st <= S_OUT;
                            end else begin
                                r_da <= w_last; r_pos <= r_rspos; r_st <= S_RD2;
                            end
                        end
                        default: begin
                            if (!w_live) begin
                                r_res.status <= ST_STALE; r_st <= S_OUT;
                            end else begin
                                r_da <= r_rspos[SLOT_BITS-1:0]; r_st <= S_RD2;
                            end
                        end
                    endcase
                end
                S_RD2: r_st <= S_ACT;
                S_ACT: begin
                    if (r_req == REQ_EVAL) begin
                        r_st <= S_DIV;
                    end else begin
                        // Move the last entry into the hole and free the slot.
                        m_dhdl[r_pos[SLOT_BITS-1:0]] <= r_rdhdl;
                        m_dfrm[r_pos[SLOT_BITS-1:0]] <= r_rdfrm;
                        m_ddur[r_pos[SLOT_BITS-1:0]] <= r_rddur;
                        m_spos[r_sa] <= POS_BITS'(SLOTS);
                        if (r_live != POS_BITS'(SLOTS)) m_snxt[r_tail] <= r_sa;
                        else r_head <= r_sa;
                        r_tail <= r_sa;
                        r_live <= r_live - POS_BITS'(1);
                        r_st <= S_FIX;
                    end
                end
                S_FIX: begin
                    // Point the moved entry's slot at the hole; when the freed
                    // slot moved onto itself it stays marked free.
                    if (r_rdhdl[SLOT_BITS-1:0] != r_sa)
                        m_spos[r_rdhdl[SLOT_BITS-1:0]] <= r_pos;
                    r_st <= S_OUT;
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_res.frame_sel <= w_rsp.frame_sel;
                        r_res.unit_out <= r_unit;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/ght_div.sv -----
// Bit-serial divider for floor(t * frames / duration), clamped to frames - 1.
// Zero frames give 0 and a zero duration gives frames - 1. Depends on ght_pkg.
module ght_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ght_pkg::t_div_cmd i_cmd,
    output ght_pkg::t_div_rsp o_rsp
);
    import ght_pkg::*;

    // Control and the product, which is built one frame bit per cycle.
    logic [1:0]  r_phase, n_phase;
    logic [5:0]  r_cnt, n_cnt;
    logic [47:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [47:0] r_quo, n_quo;
    logic [15:0] r_frm, n_frm;
    logic [15:0] r_fsh, n_fsh;
    logic [31:0] r_mcand, n_mcand;
    logic [31:0] r_dur, n_dur;
    logic [15:0] r_res, n_res;
    logic        r_done, n_done;
    logic [32:0] w_trial;
    logic [15:0] w_lim;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    assign w_trial = {r_rem[31:0], r_num[47]} - {1'b0, r_dur};
    assign w_lim   = r_frm - 16'd1;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_num = r_num; n_rem = r_rem;
        n_quo = r_quo; n_frm = r_frm; n_fsh = r_fsh; n_mcand = r_mcand;
        n_dur = r_dur; n_res = r_res; n_done = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd.start) begin
                    n_phase = PH_MUL; n_cnt = 6'd0; n_num = '0;
                    n_mcand = i_cmd.play_time; n_frm = i_cmd.frames;
                    n_fsh = i_cmd.frames; n_dur = i_cmd.duration;
                end
            end
            // Shift-add multiply, most significant frame bit first.
            PH_MUL: begin
                n_num = (r_num << 1) + (r_fsh[15] ? {16'd0, r_mcand} : 48'd0);
                n_fsh = r_fsh << 1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd15) begin
                    n_phase = PH_DIV; n_cnt = 6'd0; n_rem = '0; n_quo = '0;
                end
            end
            // Restoring division, one quotient bit per cycle.
            PH_DIV: begin
                if (!w_trial[32]) begin
                    n_rem = w_trial; n_quo = {r_quo[46:0], 1'b1};
                end else begin
                    n_rem = {r_rem[31:0], r_num[47]}; n_quo = {r_quo[46:0], 1'b0};
                end
                n_num = r_num << 1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd47) n_phase = PH_FIN;
            end
            PH_FIN: begin
                if (r_frm == 16'd0) n_res = 16'd0;
                else if (r_dur == 32'd0 || r_quo > {32'd0, w_lim}) n_res = w_lim;
                else n_res = r_quo[15:0];
                n_done = 1'b1; n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_done <= 1'b0;
        end else begin
            r_phase <= n_phase; r_done <= n_done;
        end
        r_cnt <= n_cnt; r_num <= n_num; r_rem <= n_rem; r_quo <= n_quo;
        r_frm <= n_frm; r_fsh <= n_fsh; r_mcand <= n_mcand; r_dur <= n_dur;
        r_res <= n_res;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.frame_sel = r_res;
endmodule

// ----- sv/ght_check.sv -----
// Port checker for the generational handle table core, with its bind.
// Depends on ght_pkg for the status codes.
module ght_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [87:0]  m_axis_tdata
);
    import ght_pkg::*;

    // A waiting result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No request is taken while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");

    // Status is always one of the defined codes.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_FULL
                           || m_axis_tdata[1:0] == ST_STALE))
        else $error("bad status code");

    // An item that failed carries no handle.
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[33:2] == 32'd0)
        else $error("failed item carries a handle");
endmodule

bind generational_handle_table_core ght_check u_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ----- tb/generational_handle_table_core_tb.sv -----
// Testbench for generational_handle_table_core: drives request items on the
// slave stream, predicts each result with a behavioral slot map and compares
// the master stream field by field. Depends on ght_pkg and the core.
module generational_handle_table_core_tb;
    import ght_pkg::*;

    localparam int MAX_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 100;

    // One request item as it is packed into tuser and tdata.
    typedef struct {
        logic [1:0]  req_type;
        logic [31:0] handle;
        logic [15:0] frame_count;
        logic [31:0] duration;
        logic [31:0] play_time;
        logic [31:0] unit_id;
    } t_request;

    // Directed row: request plus an optional typed-in result.
    typedef struct {
        t_request req;
        bit       fixed;
        t_result  res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // req_type
    logic [1:0]   s_axis_tuser;
    // handle, frame_count, duration, play_time, unit_id from bit 0
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // status, new_handle, present, frame_sel, unit_out from bit 0
    logic [87:0]  m_axis_tdata;

    generational_handle_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Slot map state mirrored by the predictor.
    logic [31:0] slot_hdl [SLOTS];
    int          slot_pos [SLOTS];
    int          slot_link [SLOTS];
    logic [31:0] pk_hdl [SLOTS];
    logic [15:0] pk_frames [SLOTS];
    logic [31:0] pk_dur [SLOTS];
    int          head_slot, tail_slot, n_live;

    t_result     pending_results [$];
    logic [31:0] live_handles [$];
    logic [31:0] dead_handles [$];
    int          errors = 0;
    int          cycles = 0;
    bit          sink_stall_on = 1;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("[generational_handle_table_core] ERROR");
            $finish;
        end
    end

    function automatic bit handle_live(logic [31:0] h);
        int s;
        s = h[INDEX_BITS-1:0];
        if (s >= SLOTS) return 0;
        return slot_pos[s] < SLOTS && slot_hdl[s] == h;
    endfunction

    function automatic logic [15:0] pick_frame(logic [31:0] t, logic [15:0] frames,
                                               logic [31:0] dur);
        logic [63:0] q;
        if (frames == 0) return 16'd0;
        if (dur == 0) q = '1;
        else q = (64'(t) * 64'(frames)) / 64'(dur);
        if (q > 64'(frames - 16'd1)) q = 64'(frames - 16'd1);
        return q[15:0];
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < SLOTS; i++) begin
            slot_hdl[i] = i;
            slot_pos[i] = SLOTS;
            slot_link[i] = (i + 1) % (1 << INDEX_BITS);
            pk_hdl[i] = '0;
            pk_frames[i] = '0;
            pk_dur[i] = '0;
        end
        head_slot = 0;
        tail_slot = SLOTS - 1;
        n_live = 0;
    endfunction

    // Advance the slot map by one request and return its result.
    function automatic t_result table_step(t_request r);
        t_result res;
        int s, p, last, ms;
        res = '0;
        case (r.req_type)
            REQ_CREATE: begin
                if (n_live >= SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    s = head_slot;
                    head_slot = slot_link[s];
                    slot_hdl[s] = slot_hdl[s] + (32'd1 << INDEX_BITS);
                    slot_pos[s] = n_live;
                    pk_hdl[n_live] = slot_hdl[s];
                    pk_frames[n_live] = r.frame_count;
                    pk_dur[n_live] = r.duration;
                    n_live++;
                    res.new_handle = slot_hdl[s];
                end
            end
            REQ_DESTROY: begin
                if (!handle_live(r.handle)) begin
                    res.status = ST_STALE;
                end else begin
                    s = r.handle[INDEX_BITS-1:0];
                    p = slot_pos[s];
                    last = n_live - 1;
                    pk_hdl[p] = pk_hdl[last];
                    pk_frames[p] = pk_frames[last];
                    pk_dur[p] = pk_dur[last];
                    ms = pk_hdl[p][INDEX_BITS-1:0];
                    if (ms < SLOTS) slot_pos[ms] = p;
                    slot_pos[s] = SLOTS;
                    if (n_live == SLOTS) head_slot = s;
                    else slot_link[tail_slot] = s;
                    tail_slot = s;
                    n_live = last;
                end
            end
            REQ_HAS: res.present = handle_live(r.handle);
            default: begin
                if (!handle_live(r.handle)) begin
                    res.status = ST_STALE;
                end else begin
                    p = slot_pos[r.handle[INDEX_BITS-1:0]];
                    res.frame_sel = pick_frame(r.play_time, pk_frames[p], pk_dur[p]);
                    res.unit_out = r.unit_id;
                end
            end
        endcase
        return res;
    endfunction

    // Keep the pools of known live and retired handles for random requests.
    function automatic void track_handles(t_request r, t_result res);
        if (r.req_type == REQ_CREATE && res.status == ST_OK) begin
            live_handles = {live_handles, res.new_handle};
        end else if (r.req_type == REQ_DESTROY && res.status == ST_OK) begin
            foreach (live_handles[i]) begin
                if (live_handles[i] == r.handle) begin
                    live_handles.delete(i);
                    break;
                end
            end
            dead_handles = {dead_handles, r.handle};
            if (dead_handles.size() > 64) void'(dead_handles.pop_front());
        end
    endfunction

    // Drive one item and wait for its acceptance; the expectation is queued then.
    task automatic send_request(t_request r, bit fixed, t_result fixed_res);
        t_result res;
        s_axis_tuser <= r.req_type;
        s_axis_tdata <= {r.unit_id, r.play_time, r.duration, r.frame_count, r.handle};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        res = table_step(r);
        if (fixed && res != fixed_res) begin
            $display("%0t: table row disagrees exp=%h got=%h", $time, fixed_res, res);
            errors++;
        end
        pending_results = {pending_results, (fixed ? fixed_res : res)};
        track_handles(r, res);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= 2'($urandom);
        s_axis_tdata <= 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_request random_request();
        t_request r;
        int pick;
        r.req_type = 2'($urandom_range(0, 3));
        r.frame_count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
        r.duration = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 32'h000A_0000);
        r.play_time = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h000C_0000);
        r.unit_id = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 7 && live_handles.size() != 0)
            r.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
        else if (pick < 9 && dead_handles.size() != 0)
            r.handle = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
        else
            r.handle = $urandom;
        return r;
    endfunction

    // Receiver: stalls in a pattern of its own, with stall-free stretches.
    always @(negedge i_clk) begin
        if (cycles % 500 == 0) sink_stall_on <= ~sink_stall_on;
        m_axis_tready <= sink_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_result)-1:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result exp=none got=%h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    $display("%0t: status exp=%0d got=%0d", $time, want.status, got.status);
                if (got.new_handle != want.new_handle)
                    $display("%0t: new_handle exp=%h got=%h", $time, want.new_handle,
                             got.new_handle);
                if (got.present != want.present)
                    $display("%0t: present exp=%0d got=%0d", $time, want.present, got.present);
                if (got.frame_sel != want.frame_sel)
                    $display("%0t: frame_sel exp=%0d got=%0d", $time, want.frame_sel,
                             got.frame_sel);
                if (got.unit_out != want.unit_out)
                    $display("%0t: unit_out exp=%h got=%h", $time, want.unit_out, got.unit_out);
                if (got != want) errors++;
            end
        end
    end

    initial begin
        t_row rows [$];
        t_row row;
        t_request r;
        int sent, burst;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        table_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: stale handles on an empty table, first creates and
        // evaluates at the extremes, then destroys including the last one created.
        row = '{'{REQ_HAS, 32'h0, 16'd1, 32'd1, 32'd0, 32'd0}, 1, '0};
        rows = {rows, row};
        row = '{'{REQ_DESTROY, 32'hFFFF_FFFF, 16'd1, 32'd1, 32'd0, 32'd0}, 1,
                '{32'd0, 16'd0, 1'b0, 32'd0, ST_STALE}};
        rows = {rows, row};
        row = '{'{REQ_EVAL, 32'h0000_0100, 16'd1, 32'd1, 32'd5, 32'hFFFF_FFFF}, 1,
                '{32'd0, 16'd0, 1'b0, 32'd0, ST_STALE}};
        rows = {rows, row};
        row = '{'{REQ_CREATE, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1,
                '{32'd0, 16'd0, 1'b0, 32'h0000_0100, ST_OK}};
        rows = {rows, row};
        row = '{'{REQ_CREATE, 32'hFFFF_FFFF, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
                '{32'd0, 16'd0, 1'b0, 32'h0000_0101, ST_OK}};
        rows = {rows, row};
        row = '{'{REQ_CREATE, 32'h0, 16'd10, 32'd0, 32'd0, 32'd0}, 0, '0};
        rows = {rows, row};
        row = '{'{REQ_CREATE, 32'h0, 16'd8, 32'h0004_0000, 32'd0, 32'd0}, 0, '0};
        rows = {rows, row};
        row = '{'{REQ_HAS, 32'h0000_0100, 16'd0, 32'd0, 32'd0, 32'd0}, 1,
                '{32'd0, 16'd0, 1'b1, 32'd0, ST_OK}};
        rows = {rows, row};
        row = '{'{REQ_EVAL, 32'h0000_0100, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'hA5A5_5A5A}, 1,
                '{32'hA5A5_5A5A, 16'hFFFE, 1'b0, 32'd0, ST_OK}};
        rows = {rows, row};
        row = '{'{REQ_EVAL, 32'h0000_0100, 16'd0, 32'd0, 32'd0, 32'h1}, 0, '0};
        rows = {rows, row};
        row = '{'{REQ_EVAL, 32'h0000_0101, 16'd0, 32'd0, 32'd77, 32'h2}, 0, '0};
        rows = {rows, row};
        row = '{'{REQ_EVAL, 32'h0000_0102, 16'd0, 32'd0, 32'd123, 32'h3}, 0, '0};
        rows = {rows, row};
        row = '{'{REQ_EVAL, 32'h0000_0103, 16'd0, 32'd0, 32'h0002_0000, 32'h4}, 0, '0};
        rows = {rows, row};
        row = '{'{REQ_EVAL, 32'h0000_0103, 16'd0, 32'd0, 32'h0009_0000, 32'h5}, 0, '0};
        rows = {rows, row};
        row = '{'{REQ_DESTROY, 32'h0000_0100, 16'd0, 32'd0, 32'd0, 32'd0}, 1, '0};
        rows = {rows, row};
        row = '{'{REQ_DESTROY, 32'h0000_0100, 16'd0, 32'd0, 32'd0, 32'd0}, 1,
                '{32'd0, 16'd0, 1'b0, 32'd0, ST_STALE}};
        rows = {rows, row};
        row = '{'{REQ_EVAL, 32'h0000_0103, 16'd0, 32'd0, 32'h0001_0000, 32'h6}, 0, '0};
        rows = {rows, row};
        row = '{'{REQ_DESTROY, 32'h0000_0103, 16'd0, 32'd0, 32'd0, 32'd0}, 0, '0};
        rows = {rows, row};
        row = '{'{REQ_HAS, 32'h0000_0103, 16'd0, 32'd0, 32'd0, 32'd0}, 1, '0};
        rows = {rows, row};
        foreach (rows[i]) send_request(rows[i].req, rows[i].fixed, rows[i].res);

        // Fill the table to capacity, hit the full case, and drain it partly.
        while (n_live < SLOTS) begin
            r = random_request();
            r.req_type = REQ_CREATE;
            send_request(r, 0, '0);
        end
        r = random_request();
        r.req_type = REQ_CREATE;
        send_request(r, 1, '{32'd0, 16'd0, 1'b0, 32'd0, ST_FULL});
        // Sender holds off until every result is back.
        wait_drained();
        r.req_type = REQ_DESTROY;
        r.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
        send_request(r, 0, '0);
        r.req_type = REQ_CREATE;
        send_request(r, 0, '0);
        repeat (200) begin
            r = random_request();
            r.req_type = REQ_DESTROY;
            if (live_handles.size() != 0) r.handle = live_handles[0];
            send_request(r, 0, '0);
        end

        // Random phase in bursts, weighted toward live handles.
        sent = 0;
        while (sent < 720) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                send_request(random_request(), 0, '0);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[generational_handle_table_core] OK");
        end else begin
            $display("[generational_handle_table_core] ERROR");
        end
        $finish;
    end
endmodule

// ----- generational_handle_table_core.f -----
sv/ght_pkg.sv
sv/ght_div.sv
sv/generational_handle_table_core.sv
sv/ght_check.sv
tb/generational_handle_table_core_tb.sv
